>>> sv/bsfr_pkg.sv
package bsfr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned TDATA_W = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_MARKER     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_XOR = 2'd2;

  localparam logic [BYTE_W-1:0] MARKER_RST     = 8'h7E;
  localparam logic [BYTE_W-1:0] ESCAPE_RST     = 8'h7D;
  localparam logic [BYTE_W-1:0] ESCAPE_XOR_RST = 8'h20;

  typedef struct packed {
    logic [BYTE_W-1:0] marker;
    logic [BYTE_W-1:0] escape;
    logic [BYTE_W-1:0] escape_xor;
  } cfg_t;

  typedef struct packed {
    logic              store_valid;
    logic [IDX_W-1:0]  store_index;
    logic [BYTE_W-1:0] store_byte;
    logic              frame_done;
    logic [LEN_W-1:0]  frame_length;
    logic              checksum_ok;
  } res_t;

endpackage

>>> sv/bsfr_decode.sv
module bsfr_decode import bsfr_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 64,
  parameter int unsigned MIN_FRAME_BYTES = 3,
  parameter int unsigned POS_W = 8
) (
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  cfg_t              cfg_i,
  input  logic [POS_W-1:0]  pos_i,
  input  logic              esc_i,
  input  logic [15:0]       sum_i,
  input  logic [BYTE_W-1:0] last_i,
  output logic [POS_W-1:0]  pos_o,
  output logic              esc_o,
  output logic [15:0]       sum_o,
  output logic [BYTE_W-1:0] last_o,
  output res_t              res_o
);

  logic [POS_W-1:0]  pos_m1;
  logic [BYTE_W-1:0] folded;
  logic [BYTE_W-1:0] data;

  assign pos_m1 = pos_i - POS_W'(1);
  // one's-complement style fold of the running sum, then invert
  assign folded = ~(sum_i[7:0] + sum_i[15:8]);
  assign data   = esc_i ? (rx_byte_i ^ cfg_i.escape_xor) : rx_byte_i;

  always_comb begin
    pos_o  = pos_i;
    esc_o  = esc_i;
    sum_o  = sum_i;
    last_o = last_i;
    res_o  = '0;
    if (rx_byte_i == cfg_i.marker) begin
      esc_o = 1'b0;
      if (pos_i <= POS_W'(MIN_FRAME_BYTES)) begin
        // short frame or idle gap: restart
        pos_o  = POS_W'(1);
        sum_o  = '0;
        last_o = '0;
      end else begin
        res_o.frame_done   = 1'b1;
        res_o.frame_length = LEN_W'({{LEN_W{1'b0}}, pos_m1});
        res_o.checksum_ok  = (folded == last_i);
        pos_o              = '0;
      end
    end else if (pos_i != '0) begin
      if (pos_i > POS_W'(MAX_FRAME_BYTES)) begin
        // oversize: abandon silently
        pos_o = '0;
      end else if (rx_byte_i == cfg_i.escape) begin
        esc_o = 1'b1;
      end else begin
        esc_o             = 1'b0;
        res_o.store_valid = 1'b1;
        res_o.store_index = IDX_W'({{IDX_W{1'b0}}, pos_m1});
        res_o.store_byte  = data;
        sum_o             = sum_i + {8'h00, last_i};
        last_o            = data;
        pos_o             = pos_i + POS_W'(1);
      end
    end
  end

endmodule

>>> sv/byte_stuffed_frame_receiver.sv
// Byte-stuffed frame receiver: takes one line byte per beat on s_axis and
// returns exactly one result beat per input beat on m_axis, in the next cycle.
// Throughput is one byte per clock; the only stall is m_axis backpressure,
// which the single result register passes straight to s_axis_tready. The
// frame position, escape flag and checksum sum update in one pass of logic
// between the input and the result register. A result beat carries either a
// decoded data byte with its index (tuser high), a frame end with its length
// and checksum verdict (tlast high), or nothing (both low). Configuration
// writes take effect on the next beat and must only happen while idle.
module byte_stuffed_frame_receiver import bsfr_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 64,
  parameter int unsigned MIN_FRAME_BYTES = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] rx_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [5:0] store_index, [13:6] store_byte, [20:14] frame_length,
  // [21] checksum_ok, [23:22] zero
  output logic [TDATA_W-1:0]   m_axis_tdata,
  output logic                 m_axis_tuser,   // [0] store_valid
  output logic                 m_axis_tlast    // frame_done
);

  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + MIN_FRAME_BYTES + 2);

  cfg_t              cfg_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              esc_q, esc_d;
  logic [15:0]       sum_q, sum_d;
  logic [BYTE_W-1:0] last_q, last_d;
  res_t              res_q, res_d;
  logic              vld_q;
  logic              in_fire;

  assign s_axis_tready = !vld_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.marker     <= MARKER_RST;
      cfg_q.escape     <= ESCAPE_RST;
      cfg_q.escape_xor <= ESCAPE_XOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MARKER:     cfg_q.marker     <= cfg_data_i;
        REG_ESCAPE:     cfg_q.escape     <= cfg_data_i;
        REG_ESCAPE_XOR: cfg_q.escape_xor <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bsfr_decode #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .MIN_FRAME_BYTES (MIN_FRAME_BYTES),
    .POS_W           (POS_W)
  ) u_decode (
    .rx_byte_i (s_axis_tdata),
    .cfg_i     (cfg_q),
    .pos_i     (pos_q),
    .esc_i     (esc_q),
    .sum_i     (sum_q),
    .last_i    (last_q),
    .pos_o     (pos_d),
    .esc_o     (esc_d),
    .sum_o     (sum_d),
    .last_o    (last_d),
    .res_o     (res_d)
  );

  // advance frame state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      esc_q  <= 1'b0;
      sum_q  <= '0;
      last_q <= '0;
    end else if (in_fire) begin
      pos_q  <= pos_d;
      esc_q  <= esc_d;
      sum_q  <= sum_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = res_q.store_valid;
  assign m_axis_tlast  = res_q.frame_done;
  assign m_axis_tdata  = {{(TDATA_W - IDX_W - BYTE_W - LEN_W - 1){1'b0}},
                          res_q.checksum_ok, res_q.frame_length,
                          res_q.store_byte, res_q.store_index};

  a_done_xor_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tlast && m_axis_tuser))
    else $error("frame end and data byte in the same beat");

  a_done_len_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (res_q.frame_length >= LEN_W'(MIN_FRAME_BYTES)))
    else $error("frame end reported for a short frame");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(MAX_FRAME_BYTES + 1))
    else $error("frame position past maximum");

endmodule
